// ===== src/b32d_pkg.sv =====
// Shared types, constants and the symbol map of the base32 decoder.
package b32d_pkg;

    localparam int unsigned SYM_W   = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BUF_W   = 12;
    localparam int unsigned FILL_W  = 4;
    localparam int unsigned PAD_W   = 3;
    localparam int unsigned COUNT_W = 16;

    typedef struct packed {
        logic [BUF_W-1:0]   bit_buffer;
        logic [FILL_W-1:0]  bit_fill;
        logic [PAD_W-1:0]   pad_left;
        logic [COUNT_W-1:0] symbols_seen;
        logic               error_seen;
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              bad_symbol;
        logic              last;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] value;
    } t_sym;

    // Maps one raw character to its five-bit value; valid is low for
    // characters outside the alphabet.
    function automatic t_sym map_symbol(input logic [BYTE_W-1:0] c);
        t_sym r;
        r.valid = 1'b1;
        r.value = '0;
        if (c == 8'h31) begin
            r.value = 5'd0;
        end else if (c >= 8'h33 && c <= 8'h39) begin
            r.value = SYM_W'(c - 8'h33 + 8'd1);
        end else if (c >= 8'h61 && c <= 8'h6b) begin
            r.value = SYM_W'(c - 8'h61 + 8'd8);
        end else if (c >= 8'h6d && c <= 8'h75) begin
            r.value = SYM_W'(c - 8'h6d + 8'd19);
        end else if (c >= 8'h77 && c <= 8'h7a) begin
            r.value = SYM_W'(c - 8'h77 + 8'd28);
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/b32d_if.sv =====
// Valid/ready channel interfaces for characters in and decoded results out.
interface b32d_sym_if
    import b32d_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] symbol_char;

    modport source (output valid, output symbol_char, input ready);
    modport sink   (input valid, input symbol_char, output ready);
endinterface

interface b32d_res_if
    import b32d_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              bad_symbol;
    logic              last;

    modport source (output valid, output data_byte, output has_byte,
                    output bad_symbol, output last, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input bad_symbol, input last, output ready);
endinterface

// ===== src/b32d_step.sv =====
// Next-state and result logic for one character of the string.
module b32d_step
    import b32d_pkg::*;
(
    input  t_state             i_state,
    input  logic [BYTE_W-1:0]  i_char,
    input  logic [COUNT_W-1:0] i_eff_count,
    output t_state             o_state,
    output t_result            o_result,
    output logic               o_emit
);

    t_sym               sym;
    logic [PAD_W-1:0]   pad;
    logic [COUNT_W:0]   seen_next;
    logic               is_end;
    logic [BUF_W-1:0]   buf_shift;
    logic [FILL_W-1:0]  fill_add;
    logic [FILL_W-1:0]  drop;
    logic [FILL_W-1:0]  fill_pad;
    logic [BUF_W-1:0]   buf_pad;
    logic               have_byte;
    logic [FILL_W-1:0]  fill_out;
    logic [BUF_W-1:0]   buf_out;
    logic [BYTE_W-1:0]  byte_val;

    function automatic logic [BUF_W-1:0] low_mask(input logic [FILL_W-1:0] f);
        logic [BUF_W:0] m;
        m = ({{BUF_W{1'b0}}, 1'b1} << f) - {{BUF_W{1'b0}}, 1'b1};
        return m[BUF_W-1:0];
    endfunction

    always_comb begin
        sym       = map_symbol(i_char);
        // The padding is loaded from the count at the string's first character.
        pad       = (i_state.symbols_seen == '0) ?
                    PAD_W'(i_eff_count[PAD_W-1:0] * 3'd5) : i_state.pad_left;
        seen_next = {1'b0, i_state.symbols_seen} + {{COUNT_W{1'b0}}, 1'b1};
        is_end    = seen_next >= {1'b0, i_eff_count};

        buf_shift = {i_state.bit_buffer[BUF_W-SYM_W-1:0], sym.value};
        fill_add  = i_state.bit_fill + FILL_W'(SYM_W);
        drop      = ({1'b0, pad} < fill_add) ? {1'b0, pad} : fill_add;
        fill_pad  = fill_add - drop;
        buf_pad   = buf_shift & low_mask(fill_pad);

        have_byte = fill_pad >= FILL_W'(BYTE_W);
        byte_val  = '0;
        fill_out  = fill_pad;
        buf_out   = buf_pad;
        if (have_byte) begin
            byte_val = BYTE_W'(buf_pad >> (fill_pad - FILL_W'(BYTE_W)));
            fill_out = fill_pad - FILL_W'(BYTE_W);
            buf_out  = buf_pad & low_mask(fill_out);
        end

        o_state  = i_state;
        o_result = '0;
        o_emit   = 1'b0;

        if (i_state.error_seen) begin
            // The rest of a rejected string is swallowed.
            o_state.symbols_seen = seen_next[COUNT_W-1:0];
        end else if (!sym.valid) begin
            o_result.bad_symbol  = 1'b1;
            o_result.last        = 1'b1;
            o_emit               = 1'b1;
            o_state.error_seen   = 1'b1;
            o_state.symbols_seen = seen_next[COUNT_W-1:0];
        end else begin
            o_state.bit_buffer   = buf_out;
            o_state.bit_fill     = fill_out;
            o_state.pad_left     = pad - drop[PAD_W-1:0];
            o_state.symbols_seen = seen_next[COUNT_W-1:0];
            o_result.data_byte   = byte_val;
            o_result.has_byte    = have_byte;
            o_result.last        = is_end;
            o_emit               = have_byte || is_end;
        end

        if (is_end) begin
            o_state = '0;
        end
    end

endmodule

// ===== src/base32_custom_decoder.sv =====
// Top level of the base32 decoder: input register, string state and result register.
//
//   Channel   Direction  Transaction
//   i_sym     in         one raw character of the encoded string
//   o_res     out        one decoded byte, an end marker or an error marker
//   i_cfg_*   in         write of the string's character count
//
// A character accepted on i_sym is decoded while it sits in the input register,
// and its result is written to the output register once that register is free.
// One character can be accepted in every cycle while o_res is not stalled; the single
// pass of the symbol map and buffer shift between the two registers sets the rate.
// A stall on o_res holds the output register; i_sym.ready falls only once the
// input register is full as well. Reset is synchronous and clears the string
// state, both valid flags, and sets the count to one.
module base32_custom_decoder
    import b32d_pkg::*;
#(
    parameter longint unsigned MAX_SYMBOLS = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    b32d_sym_if.sink           i_sym,
    b32d_res_if.source         o_res,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata
);

    logic [COUNT_W-1:0] r_count;
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_char;
    t_state             r_state;
    t_state             n_state;
    logic               r_out_valid;
    t_result            r_out;
    t_result            n_out;
    logic               n_emit;
    logic               out_free;
    logic               advance;
    logic [COUNT_W-1:0] eff_count;

    // A count of zero is taken as one, and one above the limit as the limit.
    always_comb begin
        if (r_count == '0) begin
            eff_count = COUNT_W'(1);
        end else if (64'(r_count) > 64'(MAX_SYMBOLS)) begin
            eff_count = COUNT_W'(MAX_SYMBOLS);
        end else begin
            eff_count = r_count;
        end
    end

    assign out_free    = !r_out_valid || o_res.ready;
    assign advance     = r_in_valid && out_free;
    assign i_sym.ready = !r_in_valid || out_free;

    b32d_step u_step (
        .i_state     (r_state),
        .i_char      (r_in_char),
        .i_eff_count (eff_count),
        .o_state     (n_state),
        .o_result    (n_out),
        .o_emit      (n_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_W'(1);
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (i_sym.ready) begin
                r_in_valid <= i_sym.valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= advance && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sym.valid && i_sym.ready) begin
            r_in_char <= i_sym.symbol_char;
        end
        if (advance && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.data_byte  = r_out.data_byte;
    assign o_res.has_byte   = r_out.has_byte;
    assign o_res.bad_symbol = r_out.bad_symbol;
    assign o_res.last       = r_out.last;

endmodule

// ===== tb/base32_custom_decoder_tb.sv =====
// Self-checking testbench for the base32 decoder: directed table, random strings, stalls.
`timescale 1ns / 100ps

module base32_custom_decoder_tb;
    import b32d_pkg::*;

    localparam longint unsigned MAX_SYMBOLS  = 65535;
    localparam int              RANDOM_ITEMS = 680;
    localparam int              DRAIN_CYCLES = 4;
    localparam int              LONG_HOLD    = 48;
    localparam int              TIMEOUT_NS   = 2_000_000;

    // The 32 symbols in value order, first symbol in the top byte.
    localparam logic [8*32-1:0] ALPHABET = "13456789abcdefghijkmnopqrstuwxyz";

    localparam t_result END_ONLY  = '{8'h00, 1'b0, 1'b0, 1'b1};
    localparam t_result REJECTED  = '{8'h00, 1'b0, 1'b1, 1'b1};
    localparam t_result ONES_BYTE = '{8'hff, 1'b1, 1'b0, 1'b0};
    localparam t_result ONES_LAST = '{8'hff, 1'b1, 1'b0, 1'b1};
    localparam t_result NO_RESULT = '{8'h00, 1'b0, 1'b0, 1'b0};

    typedef struct packed {
        bit          is_cfg;
        bit          typed;
        bit          fires;
        logic [15:0] value;
        t_result     res;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_wdata;

    b32d_sym_if sym_ch ();
    b32d_res_if res_ch ();

    base32_custom_decoder #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sym      (sym_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Decoder state as the testbench tracks it.
    logic [COUNT_W-1:0] char_count  = 16'd1;
    logic [BUF_W-1:0]   bit_pool    = '0;
    logic [FILL_W-1:0]  pool_fill   = '0;
    logic [PAD_W-1:0]   pad_bits    = '0;
    logic [COUNT_W-1:0] chars_seen  = '0;
    logic               reject_rest = 1'b0;

    t_result expected_q[$];

    int  mismatches    = 0;
    int  chars_sent    = 0;
    int  count_writes  = 0;
    int  bytes_seen    = 0;
    int  rejects_seen  = 0;
    int  byteless_ends = 0;
    bit  sym_steady    = 1'b0;
    bit  long_hold_req = 1'b0;

    t_row directed_plan[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int symbol_value(input logic [7:0] c);
        int v;
        v = -1;
        for (int i = 0; i < 32; i++)
            if (ALPHABET[8*(31-i) +: 8] == c) v = i;
        return v;
    endfunction

    function automatic void restart_string();
        bit_pool    = '0;
        pool_fill   = '0;
        pad_bits    = '0;
        chars_seen  = '0;
        reject_rest = 1'b0;
    endfunction

    // Advances the tracked state by one character; returns 1 when a result is due.
    function automatic bit decode_char(input logic [7:0] c, output t_result r);
        int unsigned eff;
        int unsigned n;
        int          sym;
        logic [3:0]  drop;
        logic [12:0] keep;
        bit          at_end;
        r = '0;
        eff = (char_count == 0) ? 1 : char_count;
        if (eff > MAX_SYMBOLS) eff = 32'(MAX_SYMBOLS);
        if (chars_seen == 0) begin
            restart_string();
            pad_bits = 3'((eff * 5) & 7);
        end
        n = chars_seen + 1;
        at_end = (n >= eff);
        if (reject_rest) begin
            if (at_end) restart_string(); else chars_seen = 16'(n);
            return 1'b0;
        end
        sym = symbol_value(c);
        if (sym < 0) begin
            r.bad_symbol = 1'b1;
            r.last       = 1'b1;
            if (at_end) begin
                restart_string();
            end else begin
                reject_rest = 1'b1;
                chars_seen  = 16'(n);
            end
            return 1'b1;
        end
        bit_pool  = {bit_pool[6:0], 5'(sym)};
        pool_fill = pool_fill + 4'd5;
        // Leading pad bits are dropped as soon as they arrive.
        drop = (4'(pad_bits) < pool_fill) ? 4'(pad_bits) : pool_fill;
        pool_fill = pool_fill - drop;
        pad_bits  = pad_bits - 3'(drop);
        keep = (13'd1 << pool_fill) - 13'd1;
        bit_pool = bit_pool & keep[11:0];
        if (pool_fill >= 4'd8) begin
            r.data_byte = 8'(bit_pool >> (pool_fill - 4'd8));
            r.has_byte  = 1'b1;
            pool_fill   = pool_fill - 4'd8;
            keep = (13'd1 << pool_fill) - 13'd1;
            bit_pool = bit_pool & keep[11:0];
        end
        if (at_end) restart_string(); else chars_seen = 16'(n);
        r.last = at_end;
        return r.has_byte || at_end;
    endfunction

    function automatic t_row cfg_row(input logic [15:0] v);
        return '{1'b1, 1'b0, 1'b0, v, NO_RESULT};
    endfunction

    function automatic t_row sym_row(input logic [7:0] c);
        return '{1'b0, 1'b0, 1'b0, {8'h00, c}, NO_RESULT};
    endfunction

    function automatic t_row sym_row_exp(input logic [7:0] c, input bit fires, input t_result r);
        return '{1'b0, 1'b1, fires, {8'h00, c}, r};
    endfunction

    // Offers one character; a typed expectation, when given, replaces the prediction.
    task automatic send_char(input logic [7:0] c, input bit typed, input bit fires,
                             input t_result typed_res);
        int      gap;
        int      r;
        t_result pred;
        bit      due;
        gap = 0;
        if (!sym_steady) begin
            r = $urandom_range(0, 99);
            if (r >= 90) gap = $urandom_range(8, 30);
            else if (r >= 50) gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            sym_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sym_ch.valid       <= 1'b1;
        sym_ch.symbol_char <= c;
        do @(posedge i_clk); while (!sym_ch.ready);
        due = decode_char(c, pred);
        if (typed) begin
            if (fires) expected_q.push_back(typed_res);
        end else if (due) begin
            expected_q.push_back(pred);
        end
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        sym_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        // A swallowed character may still be in the pipeline.
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [15:0] v);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        char_count = v;
        count_writes++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result receiver: random short stalls, occasional long ones, and a forced
    // long hold-off whenever the stimulus asks for back-pressure.
    initial begin : result_sink
        int stall_left;
        int window;
        bit steady;
        stall_left = 0;
        window     = 0;
        steady     = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (window == 0) begin
                window = 64;
                steady = ($urandom_range(0, 3) == 0);
            end
            window--;
            if (stall_left == 0 && !steady) begin
                if ($urandom_range(0, 99) < 3) stall_left = $urandom_range(10, 40);
                else if ($urandom_range(0, 99) < 30) stall_left = $urandom_range(1, 3);
            end
            if (stall_left != 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.data_byte, res_ch.has_byte, res_ch.bad_symbol, res_ch.last};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, %s%0h has=%0b bad=%0b last=%0b",
                         $time, "actual byte=", got.data_byte, got.has_byte,
                         got.bad_symbol, got.last);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                compare_field("data_byte", want.data_byte, got.data_byte);
                compare_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
                compare_field("bad_symbol", 8'(want.bad_symbol), 8'(got.bad_symbol));
                compare_field("last", 8'(want.last), 8'(got.last));
                if (want.has_byte) bytes_seen++;
                else if (want.bad_symbol) rejects_seen++;
                else byteless_ends++;
            end
        end
    end

    initial begin : stimulus
        int          phase;
        int          len;
        int          bad_at;
        int          k;
        int unsigned eff;
        logic [15:0] cnt;
        logic [7:0]  c;
        bit          pressure;
        bit          cut;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        sym_ch.valid       = 1'b0;
        sym_ch.symbol_char = '0;

        directed_plan = '{
            // Count of one after reset: the single character closes the string.
            sym_row_exp("1", 1'b1, END_ONLY),
            sym_row_exp("z", 1'b1, END_ONLY),
            sym_row_exp(8'h00, 1'b1, REJECTED),
            sym_row_exp(8'hff, 1'b1, REJECTED),
            sym_row_exp("l", 1'b1, REJECTED),
            // Eight characters, no padding: five bytes of all ones.
            cfg_row(16'd8),
            sym_row_exp("z", 1'b0, NO_RESULT),
            sym_row_exp("z", 1'b1, ONES_BYTE),
            sym_row_exp("z", 1'b0, NO_RESULT),
            sym_row_exp("z", 1'b1, ONES_BYTE),
            sym_row_exp("z", 1'b1, ONES_BYTE),
            sym_row_exp("z", 1'b0, NO_RESULT),
            sym_row_exp("z", 1'b1, ONES_BYTE),
            sym_row_exp("z", 1'b1, ONES_LAST),
            // Bad character mid-string: the rest of the string is swallowed.
            cfg_row(16'd3),
            sym_row("k"),
            sym_row_exp(" ", 1'b1, REJECTED),
            sym_row_exp("z", 1'b0, NO_RESULT),
            sym_row("9"),
            sym_row("m"),
            sym_row("w"),
            // A count of zero behaves as one.
            cfg_row(16'd0),
            sym_row_exp("q", 1'b1, END_ONLY),
            // Count lowered mid-string: leftover bits are discarded.
            cfg_row(16'd5),
            sym_row("x"),
            sym_row("4"),
            cfg_row(16'd2),
            sym_row_exp("u", 1'b1, END_ONLY),
            sym_row_exp("2", 1'b1, REJECTED),
            sym_row_exp("3", 1'b0, NO_RESULT)
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg) begin
                wait_drained();
                write_count(directed_plan[i].value);
            end else begin
                send_char(directed_plan[i].value[7:0], directed_plan[i].typed,
                          directed_plan[i].fires, directed_plan[i].res);
            end
        end

        phase = 0;
        while (chars_sent < RANDOM_ITEMS + directed_plan.size()) begin
            wait_drained();
            pressure = (phase == 2) || (phase % 30 == 17);
            k = $urandom_range(0, 99);
            if (pressure) cnt = 16'($urandom_range(24, 48));
            else if (k < 5) cnt = 16'd0;
            else if (k < 10) cnt = 16'hffff;
            else if (k < 15) cnt = 16'd1;
            else if (k < 70) cnt = 16'($urandom_range(2, 12));
            else cnt = 16'($urandom_range(13, 48));
            write_count(cnt);
            sym_steady = pressure || ($urandom_range(0, 4) == 0);
            if (pressure) long_hold_req = 1'b1;
            eff = (cnt == 0) ? 1 : cnt;
            for (int s = 0; s < (pressure ? 1 : $urandom_range(1, 3)); s++) begin
                cut = 1'b0;
                if (cnt == 16'hffff) begin
                    len = $urandom_range(1, 40);
                    cut = 1'b1;
                end else begin
                    len = eff;
                    if (!pressure && $urandom_range(0, 9) == 0) begin
                        len = $urandom_range(1, eff);
                        cut = 1'b1;
                    end
                end
                bad_at = (!pressure && $urandom_range(0, 99) < 15) ?
                         $urandom_range(0, len - 1) : -1;
                for (int j = 0; j < len; j++) begin
                    if (j == bad_at) begin
                        do c = 8'($urandom_range(0, 255)); while (symbol_value(c) >= 0);
                    end else if ($urandom_range(0, 49) == 0) begin
                        c = 8'($urandom_range(0, 255));
                    end else begin
                        k = $urandom_range(0, 31);
                        c = ALPHABET[8*(31-k) +: 8];
                    end
                    send_char(c, 1'b0, 1'b0, NO_RESULT);
                end
                // An unfinished string carries over into the next count setting.
                if (cut) break;
            end
            sym_steady = 1'b0;
            phase++;
        end

        wait_drained();
        $display("Sent %0d characters under %0d count settings, with long receiver hold-offs.",
                 chars_sent, count_writes);
        $display("Checked %0d bytes, %0d rejected strings, %0d strings ending without a byte.",
                 bytes_seen, rejects_seen, byteless_ends);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
